// ===== rtl/sfr_pkg.sv =====
// Shared constants, register codes and types for the stream find-and-replace block.
package sfr_pkg;

    localparam int PAT_MAX   = 8;                // longest pattern held in the window
    localparam int REP_MAX   = 8;                // longest replacement
    localparam int BURST_MAX = REP_MAX + 1;      // most beats one input byte can cause
    localparam int LEN_W     = 4;
    localparam int IDX_W     = $clog2(BURST_MAX);
    localparam int WFILL_W   = $clog2(PAT_MAX + 1);

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_PAT_LEN   = 2'd0;
    localparam logic [1:0] REG_PAT_BYTES = 2'd1;
    localparam logic [1:0] REG_REP_LEN   = 2'd2;
    localparam logic [1:0] REG_REP_BYTES = 2'd3;

    typedef logic [7:0] byte_t;

    // effective configuration seen by the window logic
    typedef struct packed {
        logic [LEN_W-1:0] plen;   // clamped to PAT_MAX
        logic [63:0]      pat;
        logic [LEN_W-1:0] rlen;   // clamped to REP_MAX
        logic [63:0]      rep;
    } cfg_t;

    // beats caused by one input byte
    typedef struct packed {
        byte_t [BURST_MAX-1:0] seq;
        logic  [LEN_W-1:0]     cnt;
        logic                  last;
    } burst_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] max_v);
        clamp_len = (v > max_v) ? max_v : v;
    endfunction

endpackage

// ===== rtl/stream_find_replace.sv =====
// Top level: find-and-replace-all on a byte stream, with register port.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------
//  s_      | in  | s_tvalid / s_tready | tdata=in_byte, tlast=in_last
//  m_      | out | m_tvalid / m_tready | tdata=out_byte, tuser=byte_valid,
//          |     |                     | tlast=out_last
//  cfg     | in  | psel/penable/pready | 4 regs at byte 8*i, 64-bit data
//
//  One input beat is taken per cycle while s_tready is high, costing 0 to 9
//  output beats (0 if a byte not ending its string only fills the window or
//  completes a match with an empty replacement). The window compare and burst
//  build sit between the window registers and the burst register, which drains
//  one beat a cycle while m_tready is high; a new byte enters on its final beat.
//  Back-pressure on m_ stalls s_ through s_tready; nothing is dropped.
//  Reset (aresetn low, synchronous) clears registers, window fill and burst.
module stream_find_replace (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tuser,    // [0] byte_valid
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [sfr_pkg::LEN_W-1:0] pat_len_reg;
    logic [63:0]               pat_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0] rep_len_reg;
    logic [63:0]               rep_bytes_reg;

    logic            wr_en;
    logic [1:0]      wr_idx;
    logic            clear_win;
    logic            accept;
    logic            burst_free;
    sfr_pkg::cfg_t   cfg;
    sfr_pkg::burst_t burst;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = paddr[4:3];   // low address bits ignored
    assign clear_win = wr_en && (wr_idx == sfr_pkg::REG_PAT_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg   <= '0;
            pat_bytes_reg <= '0;
            rep_len_reg   <= '0;
            rep_bytes_reg <= '0;
        end else if (wr_en) begin
            case (wr_idx)
                sfr_pkg::REG_PAT_LEN:   pat_len_reg   <= pwdata[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_PAT_BYTES: pat_bytes_reg <= pwdata;
                sfr_pkg::REG_REP_LEN:   rep_len_reg   <= pwdata[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REP_BYTES: rep_bytes_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            sfr_pkg::REG_PAT_LEN:   prdata = {60'd0, pat_len_reg};
            sfr_pkg::REG_PAT_BYTES: prdata = pat_bytes_reg;
            sfr_pkg::REG_REP_LEN:   prdata = {60'd0, rep_len_reg};
            sfr_pkg::REG_REP_BYTES: prdata = rep_bytes_reg;
            default:                prdata = '0;
        endcase
    end

    // lengths above the window / replacement capacity are clamped
    assign cfg.plen = sfr_pkg::clamp_len(pat_len_reg, sfr_pkg::LEN_W'(sfr_pkg::PAT_MAX));
    assign cfg.pat  = pat_bytes_reg;
    assign cfg.rlen = sfr_pkg::clamp_len(rep_len_reg, sfr_pkg::LEN_W'(sfr_pkg::REP_MAX));
    assign cfg.rep  = rep_bytes_reg;

    // a new byte goes in when the burst register is empty or its final beat is taken
    assign s_tready = burst_free;
    assign accept   = s_tvalid && s_tready;

    sfr_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .clear   (clear_win),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .burst   (burst)
    );

    sfr_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .burst    (burst),
        .free     (burst_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/sfr_window.sv =====
// Match window: holds pending bytes, compares against the pattern, builds the output burst.
module sfr_window (
    input  logic           aclk,
    input  logic           aresetn,
    input  sfr_pkg::cfg_t  cfg,
    input  logic           clear,      // pattern length rewritten
    input  logic           accept,     // input beat taken this cycle
    input  sfr_pkg::byte_t in_byte,
    input  logic           in_last,
    output sfr_pkg::burst_t burst
);

    sfr_pkg::byte_t [sfr_pkg::PAT_MAX-1:0] win_reg, win_next;
    logic [sfr_pkg::WFILL_W-1:0]          fill_reg, fill_next;

    sfr_pkg::byte_t [sfr_pkg::PAT_MAX-1:0] full_win;
    logic [sfr_pkg::WFILL_W-1:0]          fill_c;
    logic [sfr_pkg::WFILL_W-1:0]          fill_inc;
    logic [sfr_pkg::WFILL_W-1:0]          plen_w;
    logic                                 full, hit;

    always_comb begin
        plen_w = sfr_pkg::WFILL_W'(cfg.plen);
        fill_c = (fill_reg >= plen_w) ? plen_w - 1'b1 : fill_reg;
        fill_inc = fill_c + 1'b1;
        full = (fill_inc == plen_w);

        for (int i = 0; i < sfr_pkg::PAT_MAX; i++) begin
            full_win[i] = (sfr_pkg::WFILL_W'(i) == fill_c) ? in_byte : win_reg[i];
        end

        hit = 1'b1;
        for (int i = 0; i < sfr_pkg::PAT_MAX; i++) begin
            if ((sfr_pkg::WFILL_W'(i) < plen_w) && (full_win[i] != cfg.pat[8*i +: 8])) begin
                hit = 1'b0;
            end
        end

        // burst contents
        burst.last = in_last;
        burst.seq  = '0;
        burst.cnt  = '0;
        if (cfg.plen == '0) begin
            burst.seq[0] = in_byte;
            for (int i = 1; i < sfr_pkg::BURST_MAX; i++) begin
                burst.seq[i] = cfg.rep[8*(i-1) +: 8];
            end
            burst.cnt = cfg.rlen + 1'b1;
        end else if (full && hit) begin
            for (int i = 0; i < sfr_pkg::REP_MAX; i++) begin
                burst.seq[i] = cfg.rep[8*i +: 8];
            end
            burst.cnt = cfg.rlen;
        end else begin
            for (int i = 0; i < sfr_pkg::PAT_MAX; i++) begin
                burst.seq[i] = full_win[i];
            end
            if (full) begin
                burst.cnt = in_last ? cfg.plen : sfr_pkg::LEN_W'(1);
            end else begin
                burst.cnt = in_last ? sfr_pkg::LEN_W'(fill_inc) : '0;
            end
        end

        // window update
        win_next  = win_reg;
        fill_next = fill_reg;
        if (cfg.plen != '0) begin
            if (full && !hit) begin
                for (int i = 0; i < sfr_pkg::PAT_MAX - 1; i++) begin
                    win_next[i] = full_win[i+1];
                end
                win_next[sfr_pkg::PAT_MAX-1] = full_win[sfr_pkg::PAT_MAX-1];
                fill_next = plen_w - 1'b1;
            end else begin
                win_next  = full_win;
                fill_next = full ? '0 : fill_inc;
            end
            if (in_last) begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (clear) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

    property p_fill_below_pat;
        @(posedge aclk) disable iff (!aresetn)
        fill_reg < sfr_pkg::WFILL_W'(sfr_pkg::PAT_MAX);
    endproperty
    a_fill_below_pat: assert property (p_fill_below_pat)
        else $error("window fill reached pattern capacity");

endmodule

// ===== rtl/sfr_burst.sv =====
// Output sequencer: holds one burst, plays one beat per m_tready cycle.
module sfr_burst (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  sfr_pkg::burst_t burst,
    output logic            free,      // can take a new burst this cycle
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tuser,
    output logic            m_tlast
);

    sfr_pkg::byte_t [sfr_pkg::BURST_MAX-1:0] seq_reg;
    logic [sfr_pkg::LEN_W-1:0]              cnt_reg;
    logic [sfr_pkg::IDX_W-1:0]              idx_reg;
    logic                                   last_reg;
    logic                                   active_reg;
    logic                                   final_beat;

    assign final_beat = (cnt_reg == '0) ||
                        (sfr_pkg::LEN_W'(idx_reg) == cnt_reg - 1'b1);
    assign free       = !active_reg || (m_tready && final_beat);

    assign m_tvalid = active_reg;
    assign m_tuser  = (cnt_reg != '0);
    assign m_tdata  = (cnt_reg != '0) ? seq_reg[idx_reg] : 8'h00;
    assign m_tlast  = last_reg && final_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
        end else if (load) begin
            active_reg <= (burst.cnt != '0) || burst.last;
            idx_reg    <= '0;
            cnt_reg    <= burst.cnt;
            last_reg   <= burst.last;
        end else if (active_reg && m_tready) begin
            if (final_beat) begin
                active_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            seq_reg <= burst.seq;
        end
    end

    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty marker beat without tlast");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && cnt_reg != '0) |-> (sfr_pkg::LEN_W'(idx_reg) < cnt_reg))
        else $error("burst index past burst length");

    a_drain_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && final_beat && !load) |=> !m_tvalid)
        else $error("burst kept valid after its final beat");

    a_no_load_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("burst loaded over pending beats");

endmodule

// ===== tb/tb_stream_find_replace.sv =====
// Self-checking testbench for stream_find_replace: find-and-replace-all on a byte stream.
module tb_stream_find_replace;

    // receiver stall styles
    localparam int RX_FREE    = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    localparam int HOLD_CYCLES = 250;   // long receiver hold-off
    localparam int SETTLE      = 16;    // cycles allowed after the last beat
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 14;

    typedef struct packed {
        sfr_pkg::byte_t data;
        logic           last;
    } src_beat_t;

    typedef struct packed {
        sfr_pkg::byte_t data;
        logic           valid;
        logic           last;
    } out_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] in_byte
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic        m_tuser;           // [0] byte_valid
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    stream_find_replace u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the block's registers and match window
    logic [3:0]     cfg_plen = '0;
    logic [63:0]    cfg_pat  = '0;
    logic [3:0]     cfg_rlen = '0;
    logic [63:0]    cfg_rep  = '0;
    sfr_pkg::byte_t win [sfr_pkg::PAT_MAX];
    int             win_fill = 0;

    src_beat_t src_q[$];            // bytes waiting to be offered
    out_beat_t rewritten_q[$];      // rewritten bytes still to come out

    int n_queued = 0, n_taken = 0, n_popped = 0;
    int n_bad = 0, n_results = 0, n_markers = 0, n_strings = 0, n_settings = 0;

    // sender burst/gap shaping
    int   burst_left = 1, gap_left = 0;
    bit   tx_dense = 1'b1;
    // receiver stall shaping
    int   rx_mode = RX_FREE;
    logic [7:0] rx_mask = 8'hA5;
    int   hold_asks = 0, hold_done = 0, hold_left = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 400000);
        $display("FAILURE");
        $finish;
    end

    // ---------------- prediction ----------------
    function automatic void expect_beat(input sfr_pkg::byte_t d, input logic v);
        out_beat_t ob;
        ob.data  = d;
        ob.valid = v;
        ob.last  = 1'b0;
        rewritten_q.push_back(ob);
    endfunction

    function automatic int expect_replacement();
        int rlen;
        rlen = (cfg_rlen > sfr_pkg::REP_MAX) ? sfr_pkg::REP_MAX : int'(cfg_rlen);
        for (int i = 0; i < rlen; i++)
            expect_beat(cfg_rep[8*i +: 8], 1'b1);
        return rlen;
    endfunction

    // rewrite one source byte, queueing every beat that it releases
    function automatic void rewrite_byte(input sfr_pkg::byte_t b, input logic last);
        int  plen, k;
        bit  hit;
        plen = (cfg_plen > sfr_pkg::PAT_MAX) ? sfr_pkg::PAT_MAX : int'(cfg_plen);
        k = 0;
        if (plen == 0) begin
            expect_beat(b, 1'b1);
            k = 1 + expect_replacement();
        end else begin
            if (win_fill >= plen)
                win_fill = plen - 1;
            win[win_fill] = b;
            win_fill++;
            if (win_fill == plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (win[i] != cfg_pat[8*i +: 8])
                        hit = 1'b0;
                if (hit) begin
                    k += expect_replacement();
                    win_fill = 0;
                end else begin
                    expect_beat(win[0], 1'b1);
                    k++;
                    for (int i = 1; i < plen; i++)
                        win[i-1] = win[i];
                    win_fill--;
                end
            end
            if (last) begin
                for (int i = 0; i < win_fill; i++) begin
                    expect_beat(win[i], 1'b1);
                    k++;
                end
                win_fill = 0;
            end
        end
        if (last) begin
            // nothing left to carry the end mark: empty marker beat
            if (k == 0)
                expect_beat(8'h00, 1'b0);
            rewritten_q[rewritten_q.size()-1].last = 1'b1;
        end
    endfunction

    // ---------------- accept / check at the rising edge ----------------
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && s_tvalid && s_tready) begin
            rewrite_byte(s_tdata, s_tlast);
            n_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (!m_tuser)
                n_markers++;
            if (rewritten_q.size() == 0) begin
                n_bad++;
                $display("%0t: unexpected beat: expected none, got data %02h valid %0b last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = rewritten_q.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.valid ||
                    m_tlast !== want.last) begin
                    n_bad++;
                    $display("%0t: beat mismatch: expected data %02h valid %0b last %0b,",
                             $time, want.data, want.valid, want.last);
                    $display("    got data %02h valid %0b last %0b",
                             m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    // ---------------- sender: bursts with random gaps ----------------
    always @(negedge aclk) begin
        bit   popped;
        logic nv;
        popped = 1'b0;
        while (n_popped < n_taken) begin
            void'(src_q.pop_front());
            n_popped++;
            popped = 1'b1;
        end
        // a beat on offer stays until it is taken
        if (!(s_tvalid && !popped)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (src_q.size() > 0) begin
                nv = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = tx_dense ? 0 : $urandom_range(1, 5);
                end
            end
            s_tvalid <= nv;
            if (nv) begin
                s_tdata <= src_q[0].data;
                s_tlast <= src_q[0].last;
            end
        end
    end

    // ---------------- receiver: stall pattern and hold-off ----------------
    always @(negedge aclk) begin
        logic rdy;
        if (hold_done != hold_asks) begin
            hold_left = HOLD_CYCLES;
            hold_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE: begin
                    rdy = 1'b1;
                end
                RX_RANDOM: begin
                    rdy = ($urandom_range(0, 2) != 0);
                end
                default: begin
                    rdy = rx_mask[0];
                    rx_mask = {rx_mask[0], rx_mask[7:1]};
                end
            endcase
        end
        m_tready <= rdy;
    end

    // ---------------- register port ----------------
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            sfr_pkg::REG_PAT_LEN: begin
                cfg_plen = val[3:0];
                win_fill = 0;       // window contents dropped
            end
            sfr_pkg::REG_PAT_BYTES: begin
                cfg_pat = val;
            end
            sfr_pkg::REG_REP_LEN: begin
                cfg_rlen = val[3:0];
            end
            sfr_pkg::REG_REP_BYTES: begin
                cfg_rep = val;
            end
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------- stimulus helpers ----------------
    task automatic push_beat(input sfr_pkg::byte_t b, input logic last);
        src_beat_t sb;
        sb.data = b;
        sb.last = last;
        src_q.push_back(sb);
        n_queued++;
    endtask

    task automatic push_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], close && (i == s.len() - 1));
        if (close)
            n_strings++;
    endtask

    // block idle: all bytes taken, all results out, then a few settle cycles
    task automatic wait_idle();
        @(negedge aclk);
        while (n_taken != n_queued || rewritten_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // strings built mostly from the pattern, with partial copies and noise
    task automatic gen_strings(input int target);
        int             n, len, plen, pick, cut, j, pos;
        sfr_pkg::byte_t b;
        plen = (cfg_plen > sfr_pkg::PAT_MAX) ? sfr_pkg::PAT_MAX : int'(cfg_plen);
        n = 0;
        while (n < target) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
            j = 0;
            while (j < len) begin
                pick = $urandom_range(0, 9);
                if (pick < 5 && plen > 0) begin
                    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
                    for (int i = 0; i < cut && j < len; i++) begin
                        push_beat(cfg_pat[8*i +: 8], j == len - 1);
                        j++;
                    end
                end else begin
                    if (pick < 8 && plen > 0) begin
                        pos = $urandom_range(0, plen - 1);
                        b = cfg_pat[8*pos +: 8];
                    end else begin
                        b = 8'($urandom);
                    end
                    push_beat(b, j == len - 1);
                    j++;
                end
            end
            n += len;
            n_strings++;
        end
    endtask

    // ---------------- main sequence ----------------
    initial begin
        logic [63:0] v;
        int          pl, rl;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty pattern and empty replacement, bytes pass through
        n_settings++;
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b1);
        n_strings++;
        wait_idle();

        // three-byte pattern, two-byte replacement; match on the final byte
        reg_write(sfr_pkg::REG_PAT_LEN,   64'h3);
        reg_write(sfr_pkg::REG_PAT_BYTES, 64'h0000_0000_0063_6261);
        reg_write(sfr_pkg::REG_REP_LEN,   64'h2);
        reg_write(sfr_pkg::REG_REP_BYTES, 64'h0000_0000_0000_5958);
        n_settings++;
        rx_mode = RX_RANDOM;
        push_text("xabcabc", 1'b1);
        push_text("ab", 1'b1);          // flush of a partial window
        push_text("q", 1'b1);
        wait_idle();

        // empty replacement: match on the last byte leaves only an end marker
        reg_write(sfr_pkg::REG_REP_LEN, 64'h0);
        n_settings++;
        push_text("abc", 1'b1);
        wait_idle();

        // empty pattern with over-long replacement: nine beats from one byte
        reg_write(sfr_pkg::REG_PAT_LEN,   64'hFFFF_FFFF_FFFF_FFF0);
        reg_write(sfr_pkg::REG_REP_LEN,   64'h0000_0000_0000_000F);
        reg_write(sfr_pkg::REG_REP_BYTES, 64'hFFEE_DDCC_BBAA_9988);
        n_settings++;
        rx_mode = RX_PATTERN;
        push_beat(8'hFF, 1'b1);
        n_strings++;
        wait_idle();

        // over-long pattern length, all-zero pattern; then stop mid-string
        reg_write(sfr_pkg::REG_PAT_LEN,   64'hF);
        reg_write(sfr_pkg::REG_PAT_BYTES, 64'h0);
        n_settings++;
        tx_dense = 1'b0;
        for (int i = 0; i < 8; i++)
            push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h11, 1'b0);
        wait_idle();
        // the pattern-length write below drops the three buffered bytes

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       begin pl = 1;  rl = 0;  end
                1:       begin pl = 8;  rl = 8;  end
                2:       begin pl = 15; rl = 15; end
                3:       begin pl = 0;  rl = $urandom_range(0, 15); end
                default: begin pl = $urandom_range(1, 6); rl = $urandom_range(0, 15); end
            endcase
            v = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 1) begin
                // two-letter alphabet gives self-overlapping patterns
                for (int i = 0; i < 8; i++)
                    v[8*i +: 8] = ($urandom_range(0, 1) == 1) ? 8'h41 : 8'h42;
            end
            reg_write(sfr_pkg::REG_PAT_BYTES, v);
            reg_write(sfr_pkg::REG_REP_BYTES, {$urandom, $urandom});
            v = {$urandom, $urandom};
            v[3:0] = 4'(rl);
            reg_write(sfr_pkg::REG_REP_LEN, v);
            v = {$urandom, $urandom};
            v[3:0] = 4'(pl);
            reg_write(sfr_pkg::REG_PAT_LEN, v);
            n_settings++;

            tx_dense = (ph % 3 == 1);
            rx_mode  = (ph + 1) % 3;
            rx_mask  = 8'($urandom) | 8'h01;
            gen_strings(PHASE_ITEMS);
            // long receiver hold-off while the sender keeps offering
            if (ph == 4)
                hold_asks++;
            wait_idle();
        end

        $display("run covered %0d input beats in %0d strings over %0d register settings,",
                 n_taken, n_strings, n_settings);
        $display("and checked %0d result beats, %0d of them empty end markers",
                 n_results, n_markers);
        if (n_bad == 0 && rewritten_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
